>>> rtl/mfcc_pkg.sv
// Shared constants, types and the CRC-8 byte update for the measurement frame checker.
package mfcc_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam int         WORD_COUNT = 3;
  localparam int         GRP_W      = 3;
  localparam logic [1:0] OFF_CHECK  = 2'd2;

  typedef logic [WORD_COUNT-1:0][31:0] word_arr_t;

  typedef struct packed {
    logic             last;
    logic             failed;
    logic [GRP_W-1:0] bad_grp;
  } res_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/mfcc_frame_core.sv
// Frame position tracking, per-group CRC check, word assembly and commit of good words.
module mfcc_frame_core import mfcc_pkg::*; #(
  parameter int FRAME_BYTES = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       stb_i,
  input  logic [7:0] byte_i,
  input  logic       start_i,
  output res_t       res_o,
  output word_arr_t  words_o
);

  localparam int PosW = $clog2(FRAME_BYTES);

  logic [PosW-1:0]  pos_q, pos_d, pos;
  logic [1:0]       off_q, off_d, off;
  logic [GRP_W-1:0] grp_q, grp_d, grp;
  logic [7:0]       crc_q, crc_d, crc_in;
  logic             failed_q, failed_d;
  logic [GRP_W-1:0] first_q, first_d;
  word_arr_t        pend_q, pend_d, good_q, good_d;
  logic [1:0]       widx;
  logic             last;

  always_comb begin
    pos  = start_i ? '0 : pos_q;
    off  = start_i ? '0 : off_q;
    grp  = start_i ? '0 : grp_q;
    widx = grp[2:1];
    last = (pos == PosW'(FRAME_BYTES - 1));

    failed_d = (pos == '0) ? 1'b0 : failed_q;
    first_d  = (pos == '0) ? '0 : first_q;
    pend_d   = (pos == '0) ? '0 : pend_q;
    crc_in   = (off == '0) ? CRC_INIT : crc_q;
    crc_d    = CRC_INIT;

    if (off != OFF_CHECK) begin
      crc_d = crc8_next(crc_in, byte_i);
      for (int i = 0; i < WORD_COUNT; i++) begin
        if (widx == 2'(i)) begin
          pend_d[i] = {pend_d[i][23:0], byte_i};
        end
      end
    end else if (crc_q != byte_i && !failed_d) begin
      failed_d = 1'b1;
      first_d  = grp;
    end

    if (last) begin
      pos_d = '0;
      off_d = '0;
      grp_d = '0;
    end else begin
      pos_d = PosW'(pos + 1'b1);
      off_d = (off == OFF_CHECK) ? 2'd0 : 2'(off + 1'b1);
      grp_d = (off == OFF_CHECK) ? GRP_W'(grp + 1'b1) : grp;
    end

    good_d = (last && !failed_d) ? pend_d : good_q;

    res_o.last    = last;
    res_o.failed  = failed_d;
    res_o.bad_grp = failed_d ? first_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      off_q    <= '0;
      grp_q    <= '0;
      crc_q    <= CRC_INIT;
      failed_q <= 1'b0;
      first_q  <= '0;
      pend_q   <= '0;
      good_q   <= '0;
    end else if (stb_i) begin
      pos_q    <= pos_d;
      off_q    <= off_d;
      grp_q    <= grp_d;
      crc_q    <= crc_d;
      failed_q <= failed_d;
      first_q  <= first_d;
      pend_q   <= pend_d;
      good_q   <= good_d;
    end
  end

  assign words_o = good_q;

endmodule

>>> rtl/measurement_frame_crc_checker_unit.sv
// Top level of the measurement frame checker: input register, frame core, result register.
// Accepts one response byte per cycle, sustained while no result is stalled, with no
// bubbles between frames. Each accepted byte is held in an input register, then the frame
// core updates the CRC-8 of its group (one unrolled byte step), assembles the data words
// and, on the last byte of a frame, loads the result register, which is offered once the
// last byte leaves the input register. Only a stalled result holds back a last byte,
// stalling the input. A frame_start byte restarts the frame, dropping any partial one.
module measurement_frame_crc_checker_unit import mfcc_pkg::*; #(
  parameter int FRAME_BYTES = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             frame_start_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      co2_bits_o,
  output logic [31:0]      temperature_bits_o,
  output logic [31:0]      humidity_bits_o,
  output logic             frame_status_o,
  output logic [GRP_W-1:0] bad_group_o
);

  logic             s1_vld_q;
  logic [7:0]       s1_byte_q;
  logic             s1_start_q;
  logic             out_vld_q;
  logic             status_q;
  logic [GRP_W-1:0] bad_q;
  logic             out_free, s1_go, in_take;
  res_t             res;
  word_arr_t        words;

  mfcc_frame_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stb_i  (s1_go),
    .byte_i (s1_byte_q),
    .start_i(s1_start_q),
    .res_o  (res),
    .words_o(words)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_go      = s1_vld_q && (!res.last || out_free);
  assign in_stall_o = s1_vld_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take || s1_go) begin
        s1_vld_q <= in_take;
      end
      if (s1_go && res.last) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= frame_start_i;
    end
    if (s1_go && res.last) begin
      status_q <= res.failed;
      bad_q    <= res.bad_grp;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign co2_bits_o         = words[0];
  assign temperature_bits_o = words[1];
  assign humidity_bits_o    = words[2];
  assign frame_status_o     = status_q;
  assign bad_group_o        = bad_q;

  a_pass_no_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !status_q |-> bad_q == '0)
    else $error("passing frame reports a failing group");

  a_group_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> bad_q <= GRP_W'((FRAME_BYTES - 1) / 3))
    else $error("failing group beyond frame");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_vld_q))
    else $error("result without a byte in the input register");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without a held result");

endmodule
